@@ sv/tcd_pkg.sv @@
// ----------------------------------------------------------------------------
// tcd_pkg
// shared types and charset codes for the text charset detector
// ----------------------------------------------------------------------------
package tcd_pkg;

    localparam logic [2:0] CS_UNKNOWN = 3'd0;
    localparam logic [2:0] CS_ANSI    = 3'd1;
    localparam logic [2:0] CS_UTF8    = 3'd2;
    localparam logic [2:0] CS_UTF16LE = 3'd3;
    localparam logic [2:0] CS_UTF16BE = 3'd4;

    localparam logic [2:0] COUNT_SAT  = 3'd5;

    // running stream checks
    typedef struct packed {
        logic            ascii_good;
        logic            gbk_good;
        logic            gbk_need_trail;
        logic            utf8_good;
        logic [1:0]      utf8_pending;
        logic            le_good;
        logic            le_wait_low;
        logic            be_good;
        logic            be_wait_low;
        logic            odd_phase;
        logic [3:0][7:0] head;
        logic [2:0]      byte_count;
    } t_stream;

    typedef struct packed {
        logic [2:0] charset;
        logic [1:0] mark_length;
        logic       accepted;
    } t_result;

endpackage

@@ sv/text_charset_detector.sv @@
// ----------------------------------------------------------------------------
// text_charset_detector
// streaming charset detector with byte-order mark and expected-charset check
// ----------------------------------------------------------------------------
// Takes one text byte per cycle on the slave stream, tlast on the final byte
// of each stream. Bytes pass an input register, then the running checks
// update and, on the final byte, the verdict is written to the result
// register, from which the result beat is sent. Input is taken every cycle
// but for one stall: a second final byte reaching the check stage while the
// previous result is still unread.
// The expected charset register should be written between streams.
module text_charset_detector (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    input  logic       i_s_axis_tlast,   // last_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [2:0] charset, [4:3] mark_length, [5] accepted
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_data        // expected_charset
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;
    logic [2:0]       r_expected;
    logic             r_out_valid;
    tcd_pkg::t_result r_out;

    logic             out_free;
    logic             step;
    tcd_pkg::t_stream next_stream;
    tcd_pkg::t_result result;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign step            = r_in_valid && (!r_in_last || out_free);
    assign o_s_axis_tready = !r_in_valid || step;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected <= tcd_pkg::CS_UNKNOWN;
        end else if (i_cfg_valid) begin
            r_expected <= i_cfg_data;
        end
    end

    tcd_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_next  (next_stream)
    );

    tcd_decide u_decide (
        .i_stream   (next_stream),
        .i_expected (r_expected),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out.accepted, r_out.mark_length, r_out.charset};

    // a new result beat only comes from a final byte leaving the check stage
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(step && r_in_last))
        else $error("result beat without a final byte");

    // the input side only stalls on a final byte blocked by an unread result
    a_stall_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_in_valid && r_in_last && r_out_valid && !i_m_axis_tready))
        else $error("input stalled without a blocked result");

    // an accepted stream always names a real charset
    a_accept_charset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_out.accepted) |-> (r_out.charset != tcd_pkg::CS_UNKNOWN))
        else $error("accepted result with unknown charset");

    // a byte-order mark length only goes with a unicode charset
    a_mark_charset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_out.mark_length != 2'd0) |->
        (r_out.charset == tcd_pkg::CS_UTF8 || r_out.charset == tcd_pkg::CS_UTF16LE
         || r_out.charset == tcd_pkg::CS_UTF16BE))
        else $error("mark length with non-unicode charset");

endmodule

@@ sv/tcd_scan.sv @@
// ----------------------------------------------------------------------------
// tcd_scan
// per-byte update of the running ascii, gbk, utf-8 and utf-16 checks
// ----------------------------------------------------------------------------
module tcd_scan (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output tcd_pkg::t_stream o_next
);

    tcd_pkg::t_stream r_state;
    tcd_pkg::t_stream n_state;

    always_comb begin
        logic [7:0] top;
        top     = i_byte & 8'hFC;
        n_state = r_state;

        if (i_byte[7]) begin
            n_state.ascii_good = 1'b0;
        end

        if (r_state.gbk_need_trail) begin
            if (i_byte < 8'h40 || i_byte == 8'hFF) begin
                n_state.gbk_good = 1'b0;
            end
            n_state.gbk_need_trail = 1'b0;
        end else if (i_byte[7]) begin
            if (i_byte == 8'h80 || i_byte == 8'hFF) begin
                n_state.gbk_good = 1'b0;
            end else begin
                n_state.gbk_need_trail = 1'b1;
            end
        end

        if (r_state.utf8_pending != 2'd0) begin
            if ((i_byte & 8'hC0) != 8'h80) begin
                n_state.utf8_good = 1'b0;
            end
            n_state.utf8_pending = r_state.utf8_pending - 2'd1;
        end else if (!i_byte[7]) begin
            n_state.utf8_pending = 2'd0;
        end else if ((i_byte & 8'hE0) == 8'hC0) begin
            n_state.utf8_pending = 2'd1;
        end else if ((i_byte & 8'hF0) == 8'hE0) begin
            n_state.utf8_pending = 2'd2;
        end else if ((i_byte & 8'hF8) == 8'hF0) begin
            n_state.utf8_pending = 2'd3;
        end else begin
            n_state.utf8_good = 1'b0;
        end

        // odd bytes carry the high half of a little-endian unit
        if (r_state.odd_phase) begin
            if (r_state.le_wait_low) begin
                if (top != 8'hDC) begin
                    n_state.le_good = 1'b0;
                end
                n_state.le_wait_low = 1'b0;
            end else if (top == 8'hD8) begin
                n_state.le_wait_low = 1'b1;
            end else if (top == 8'hDC) begin
                n_state.le_good = 1'b0;
            end
        end else begin
            if (r_state.be_wait_low) begin
                if (top != 8'hDC) begin
                    n_state.be_good = 1'b0;
                end
                n_state.be_wait_low = 1'b0;
            end else if (top == 8'hD8) begin
                n_state.be_wait_low = 1'b1;
            end else if (top == 8'hDC) begin
                n_state.be_good = 1'b0;
            end
        end
        n_state.odd_phase = !r_state.odd_phase;

        if (r_state.byte_count < 3'd4) begin
            n_state.head[r_state.byte_count[1:0]] = i_byte;
        end
        if (r_state.byte_count < tcd_pkg::COUNT_SAT) begin
            n_state.byte_count = r_state.byte_count + 3'd1;
        end
    end

    assign o_next = n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_state.ascii_good     <= 1'b1;
            r_state.gbk_good       <= 1'b1;
            r_state.gbk_need_trail <= 1'b0;
            r_state.utf8_good      <= 1'b1;
            r_state.utf8_pending   <= 2'd0;
            r_state.le_good        <= 1'b1;
            r_state.le_wait_low    <= 1'b0;
            r_state.be_good        <= 1'b1;
            r_state.be_wait_low    <= 1'b0;
            r_state.odd_phase      <= 1'b0;
            r_state.byte_count     <= 3'd0;
        end else if (i_step) begin
            r_state.ascii_good     <= n_state.ascii_good;
            r_state.gbk_good       <= n_state.gbk_good;
            r_state.gbk_need_trail <= n_state.gbk_need_trail;
            r_state.utf8_good      <= n_state.utf8_good;
            r_state.utf8_pending   <= n_state.utf8_pending;
            r_state.le_good        <= n_state.le_good;
            r_state.le_wait_low    <= n_state.le_wait_low;
            r_state.be_good        <= n_state.be_good;
            r_state.be_wait_low    <= n_state.be_wait_low;
            r_state.odd_phase      <= n_state.odd_phase;
            r_state.byte_count     <= n_state.byte_count;
        end
        // head bytes are only read below the fill count, so they need no reset
        if (i_step) begin
            r_state.head <= n_state.head;
        end
    end

endmodule

@@ sv/tcd_decide.sv @@
// ----------------------------------------------------------------------------
// tcd_decide
// byte-order mark lookup, priority detection and expected-charset check
// ----------------------------------------------------------------------------
module tcd_decide (
    input  tcd_pkg::t_stream i_stream,
    input  logic [2:0]       i_expected,
    output tcd_pkg::t_result o_result
);

    always_comb begin
        logic [2:0] n_cnt;
        logic [2:0] mark_cs;
        logic [1:0] mark_len;
        logic [2:0] det;
        logic [2:0] cs;
        logic       ok;
        logic       utf32be;
        logic       fffe0000;

        n_cnt    = i_stream.byte_count;
        utf32be  = n_cnt >= 3'd4 && i_stream.head[0] == 8'h00 && i_stream.head[1] == 8'h00
                   && i_stream.head[2] == 8'hFE && i_stream.head[3] == 8'hFF;
        fffe0000 = n_cnt >= 3'd4 && i_stream.head[0] == 8'hFF && i_stream.head[1] == 8'hFE
                   && i_stream.head[2] == 8'h00 && i_stream.head[3] == 8'h00;

        if (n_cnt < 3'd2) begin
            mark_cs = tcd_pkg::CS_UNKNOWN;
        end else if (utf32be) begin
            mark_cs = tcd_pkg::CS_UNKNOWN;
        end else if (fffe0000) begin
            // utf-16le only when the stream is exactly these four bytes
            mark_cs = (n_cnt == 3'd4) ? tcd_pkg::CS_UTF16LE : tcd_pkg::CS_UNKNOWN;
        end else if (n_cnt >= 3'd3 && i_stream.head[0] == 8'hEF && i_stream.head[1] == 8'hBB
                     && i_stream.head[2] == 8'hBF) begin
            mark_cs = tcd_pkg::CS_UTF8;
        end else if (i_stream.head[0] == 8'hFF && i_stream.head[1] == 8'hFE) begin
            mark_cs = tcd_pkg::CS_UTF16LE;
        end else if (i_stream.head[0] == 8'hFE && i_stream.head[1] == 8'hFF) begin
            mark_cs = tcd_pkg::CS_UTF16BE;
        end else begin
            mark_cs = tcd_pkg::CS_UNKNOWN;
        end

        if (mark_cs == tcd_pkg::CS_UTF8) begin
            mark_len = 2'd3;
        end else if (mark_cs == tcd_pkg::CS_UTF16LE || mark_cs == tcd_pkg::CS_UTF16BE) begin
            mark_len = 2'd2;
        end else begin
            mark_len = 2'd0;
        end

        if (i_stream.ascii_good) begin
            det = tcd_pkg::CS_ANSI;
        end else if (i_stream.gbk_good && !i_stream.gbk_need_trail) begin
            det = (i_stream.utf8_good && i_stream.utf8_pending == 2'd0)
                  ? tcd_pkg::CS_UTF8 : tcd_pkg::CS_ANSI;
        end else if (i_stream.utf8_good && i_stream.utf8_pending == 2'd0) begin
            det = tcd_pkg::CS_UTF8;
        end else if (!i_stream.odd_phase && i_stream.le_good && !i_stream.le_wait_low) begin
            det = tcd_pkg::CS_UTF16LE;
        end else if (!i_stream.odd_phase && i_stream.be_good && !i_stream.be_wait_low) begin
            det = tcd_pkg::CS_UTF16BE;
        end else begin
            det = tcd_pkg::CS_UNKNOWN;
        end

        cs = mark_cs;
        ok = 1'b1;
        if (i_expected != tcd_pkg::CS_UNKNOWN && i_expected != mark_cs) begin
            if (mark_len != 2'd0) begin
                ok = 1'b0;
            end else if (det != i_expected) begin
                ok = 1'b0;
            end else begin
                cs = i_expected;
            end
        end
        if (ok && cs == tcd_pkg::CS_UNKNOWN) begin
            cs       = det;
            mark_len = 2'd0;
        end
        if (cs == tcd_pkg::CS_UNKNOWN) begin
            ok = 1'b0;
        end

        o_result.charset     = cs;
        o_result.mark_length = mark_len;
        o_result.accepted    = ok;
    end

endmodule
